### hdl/spq_pkg.sv
// Package for the stable priority task queue.
// Holds the queue depth, field widths, status codes and the cell types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

	localparam int DEPTH  = 16;
	localparam int PRIO_W = 8;
	localparam int HNDL_W = 16;
	localparam int OCC_W  = 5;
	localparam int CNT_W  = $clog2(DEPTH + 1);

	localparam logic REQ_PUSH = 1'b0;
	localparam logic REQ_POP  = 1'b1;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		logic                     valid;
		logic signed [PRIO_W-1:0] prio;
		logic [HNDL_W-1:0]        handle;
	} entry_t;

	typedef struct packed {
		logic                     push;
		logic                     pop;
		logic signed [PRIO_W-1:0] prio;
		logic [HNDL_W-1:0]        handle;
	} cmd_t;

endpackage

`default_nettype wire

### hdl/spq_cell.sv
// One storage cell of the sorted task chain.
// Depends on spq_pkg for the entry and command types.
`timescale 1ns / 1ps
`default_nettype none

module spq_cell
	import spq_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire cmd_t   cmd,
	input  wire entry_t left_entry,
	input  wire logic   left_ahead,
	input  wire entry_t right_entry,
	output entry_t      entry,
	output logic        ahead
);

	logic                     valid_q;
	logic signed [PRIO_W-1:0] prio_q;
	logic [HNDL_W-1:0]        handle_q;
	entry_t                   nxt;
	logic                     load;

	assign entry.valid  = valid_q;
	assign entry.prio   = prio_q;
	assign entry.handle = handle_q;

	// A new task goes ahead of this cell's task if the cell is empty or the new task has strictly higher priority.
	assign ahead = !valid_q || ($signed(cmd.prio) > $signed(prio_q));

	always_comb begin
		nxt  = entry;
		load = 1'b0;
		if (cmd.pop) begin
			nxt  = right_entry;
			load = 1'b1;
		end else if (cmd.push && ahead) begin
			load = 1'b1;
			if (left_ahead) begin
				nxt = left_entry;
			end else begin
				nxt.valid  = 1'b1;
				nxt.prio   = cmd.prio;
				nxt.handle = cmd.handle;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= nxt.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			prio_q   <= nxt.prio;
			handle_q <= nxt.handle;
		end
	end

endmodule

`default_nettype wire

### hdl/stable_priority_task_queue.sv
// Top level of the stable priority task queue.
// Depends on spq_pkg and spq_cell.
//
// Usage: a request (req_type, priority_req, task_handle) transfers at a rising
// edge where start is high and busy is low. A push stores the task; a pop
// returns the task of highest priority, the oldest one among equal priorities.
// The tasks sit in a chain of cells kept in serving order, so a request that
// succeeds updates the chain in the transfer cycle itself.
// The result appears with done high for exactly one cycle, the cycle after the
// transfer, and carries status, the popped task and the occupancy after the
// request. Busy is high during that result cycle, so the block takes no new
// request while a result is shown; busy is driven by the result register.
// A push on a full queue reports full and drops the task. A pop on an empty
// queue reports empty. Popped fields are zero unless a pop succeeds.
// Reset empties the queue and clears any pending result. The receiver cannot
// stall: each result is taken in the cycle it is shown.
`timescale 1ns / 1ps
`default_nettype none

module stable_priority_task_queue
	import spq_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	output logic                          busy,
	input  wire logic                     req_type,
	input  wire logic signed [PRIO_W-1:0] priority_req,
	input  wire logic [HNDL_W-1:0]        task_handle,
	output logic                          done,
	output logic [1:0]                    status,
	output logic signed [PRIO_W-1:0]      popped_priority,
	output logic [HNDL_W-1:0]             popped_handle,
	output logic [OCC_W-1:0]              occupancy
);

	entry_t                   entries [DEPTH];
	logic   [DEPTH-1:0]       aheads;
	logic   [DEPTH-1:0]       vbits;
	cmd_t                     cmd;
	logic                     accept;
	logic                     full;
	logic                     empty;
	logic [CNT_W-1:0]         count_q;
	logic [CNT_W-1:0]         count_nxt;
	logic                     done_q;
	status_t                  status_q;
	status_t                  status_nxt;
	logic signed [PRIO_W-1:0] pprio_q;
	logic [HNDL_W-1:0]        phandle_q;
	logic [OCC_W-1:0]         occ_q;

	assign busy   = done_q;
	assign accept = start && !busy;
	assign full   = entries[DEPTH-1].valid;
	assign empty  = !entries[0].valid;

	assign cmd.push   = accept && (req_type == REQ_PUSH) && !full;
	assign cmd.pop    = accept && (req_type == REQ_POP) && !empty;
	assign cmd.prio   = priority_req;
	assign cmd.handle = task_handle;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		entry_t left_e;
		logic   left_b;
		entry_t right_e;

		if (i == 0) begin : g_head
			assign left_e = '0;
			assign left_b = 1'b0;
		end else begin : g_body
			assign left_e = entries[i-1];
			assign left_b = aheads[i-1];
		end

		if (i == DEPTH - 1) begin : g_tail
			assign right_e = '0;
		end else begin : g_mid
			assign right_e = entries[i+1];
		end

		spq_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.cmd         (cmd),
			.left_entry  (left_e),
			.left_ahead  (left_b),
			.right_entry (right_e),
			.entry       (entries[i]),
			.ahead       (aheads[i])
		);

		assign vbits[i] = entries[i].valid;
	end

	always_comb begin
		count_nxt  = count_q;
		status_nxt = ST_OK;
		if (req_type == REQ_PUSH) begin
			if (full) begin
				status_nxt = ST_FULL;
			end else begin
				count_nxt = count_q + CNT_W'(1);
			end
		end else begin
			if (empty) begin
				status_nxt = ST_EMPTY;
			end else begin
				count_nxt = count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= accept;
			if (accept) begin
				count_q <= count_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q  <= status_nxt;
			occ_q     <= OCC_W'(count_nxt);
			pprio_q   <= cmd.pop ? entries[0].prio : '0;
			phandle_q <= cmd.pop ? entries[0].handle : '0;
		end
	end

	assign done            = done_q;
	assign status          = status_q;
	assign popped_priority = pprio_q;
	assign popped_handle   = phandle_q;
	assign occupancy       = occ_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("task count exceeds depth");

	a_count_matches: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(vbits) == int'(count_q))
		else $error("task count disagrees with occupied cells");

	a_cells_packed: assert property (@(posedge clk) disable iff (!arst_n)
		((vbits + DEPTH'(1)) & vbits) == '0)
		else $error("occupied cells are not packed at the head");

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.push && cmd.pop))
		else $error("push and pop issued to the chain together");

	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_EMPTY) |-> (occupancy == '0 && popped_handle == '0))
		else $error("empty pop result carries data");

endmodule

`default_nettype wire
